/* design/tfam_pkg.sv */
// ----------------------------------------------------------------------------
// tfam_pkg: shared types and constants for the top-five-above-mean selector
// Sizes, sequencer states and the top-k control struct.
// ----------------------------------------------------------------------------
package tfam_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int TOP_K     = 5;

  localparam int VALUE_W = 32;
  localparam int ADDR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W   = VALUE_W + ADDR_W;
  localparam int PROD_W  = VALUE_W + CNT_W + 1;
  localparam int KIDX_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int FILL_W  = $clog2(TOP_K + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef value_t best_arr_t [TOP_K];

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic insert;
    logic clear;
  } topk_ctrl_t;

endpackage

/* design/tfam_if.sv */
// ----------------------------------------------------------------------------
// tfam_in_if / tfam_out_if: valid/ready channels of the selector
// Input beats carry one sample; output beats carry one selected value.
// ----------------------------------------------------------------------------
interface tfam_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfam_pkg::VALUE_W-1:0] sample_value;
  logic                                final_item;

  modport source (output valid, sample_value, final_item, input ready);
  modport sink   (input valid, sample_value, final_item, output ready);
endinterface

interface tfam_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfam_pkg::VALUE_W-1:0] chosen_value;
  logic                                none_above;
  logic                                last_result;
  logic                                truncated;

  modport source (output valid, chosen_value, none_above, last_result, truncated,
                  input ready);
  modport sink   (input valid, chosen_value, none_above, last_result, truncated,
                  output ready);
endinterface

/* design/top_five_above_mean_select_core.sv */
// ----------------------------------------------------------------------------
// top_five_above_mean_select_core: top-five selection of values above the mean
// Stores a set of samples, then emits the largest values above the set mean, at most five.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one beat per sample; final_item marks the last sample of a set.
//           Ready only while loading, one beat per cycle.
//   out_o : after the final beat the stored samples are scanned; then up to
//           five beats in descending order, last_result on the final one.
//           With nothing above the mean a single beat with none_above = 1.
//   Samples beyond 1024 in a set are dropped and flag truncated.
// Timing: the scan reads the store once per cycle through a read / multiply /
//   insert pipeline, with the single store read port and the shared multiplier.
//   Results follow at one beat per cycle while out_o is ready.
// Stall: results are held until taken; no new set is accepted meanwhile.
// Reset: sum, count, selection and flags clear at once; the store keeps its
//   contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module top_five_above_mean_select_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  tfam_in_if.sink      in_i,
  tfam_out_if.source   out_o
);

  tfam_pkg::state_e                   state_q, state_d;
  logic [tfam_pkg::CNT_W-1:0]         count_q, count_d;
  logic signed [tfam_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic                               ovf_q, ovf_d;
  logic [tfam_pkg::ADDR_W-1:0]        scan_q, scan_d;
  logic [tfam_pkg::KIDX_W-1:0]        k_q, k_d;
  logic                               rd_vld_q, mul_vld_q;
  logic signed [tfam_pkg::PROD_W-1:0] prod_q, prod;
  tfam_pkg::value_t                   x_q;

  logic                               in_accept, out_accept, store_we, rd_en;
  logic                               none, last;
  tfam_pkg::value_t                   rdata;
  tfam_pkg::best_arr_t                best;
  logic [tfam_pkg::FILL_W-1:0]        filled;
  tfam_pkg::topk_ctrl_t               topk_ctrl;

  assign in_accept  = in_i.valid && in_i.ready;
  assign out_accept = out_o.valid && out_o.ready;
  assign store_we   = in_accept && (count_q < tfam_pkg::CNT_W'(tfam_pkg::MAX_ITEMS));

  tfam_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[tfam_pkg::ADDR_W-1:0]),
    .wdata_i (in_i.sample_value),
    .re_i    (rd_en),
    .raddr_i (scan_q),
    .rdata_o (rdata)
  );

  // x above mean  <=>  x * count > sum
  assign prod = tfam_pkg::PROD_W'(rdata)
              * tfam_pkg::PROD_W'($signed({1'b0, count_q}));

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    x_q    <= rdata;
  end

  always_comb begin
    topk_ctrl.insert = mul_vld_q && (prod_q > tfam_pkg::PROD_W'(sum_q));
    topk_ctrl.clear  = 1'b0;
    if (state_q == tfam_pkg::ST_EMIT && out_accept && last) begin
      topk_ctrl.clear = 1'b1;
    end
  end

  tfam_topk u_topk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (topk_ctrl),
    .value_i  (x_q),
    .best_o   (best),
    .filled_o (filled)
  );

  assign none = (filled == '0);
  assign last = none || ((tfam_pkg::FILL_W'(k_q) + tfam_pkg::FILL_W'(1)) == filled);

  assign in_i.ready         = (state_q == tfam_pkg::ST_LOAD);
  assign out_o.valid        = (state_q == tfam_pkg::ST_EMIT);
  assign out_o.chosen_value = none ? '0 : best[k_q];
  assign out_o.none_above   = none;
  assign out_o.last_result  = last;
  assign out_o.truncated    = ovf_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    scan_d  = scan_q;
    k_d     = k_q;
    rd_en   = 1'b0;
    unique case (state_q)
      tfam_pkg::ST_LOAD: begin
        if (in_accept) begin
          if (store_we) begin
            count_d = count_q + tfam_pkg::CNT_W'(1);
            sum_d   = sum_q + tfam_pkg::SUM_W'(in_i.sample_value);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.final_item) begin
            state_d = tfam_pkg::ST_SCAN;
            scan_d  = '0;
          end
        end
      end
      tfam_pkg::ST_SCAN: begin
        rd_en  = 1'b1;
        scan_d = scan_q + tfam_pkg::ADDR_W'(1);
        if ((tfam_pkg::CNT_W'(scan_q) + tfam_pkg::CNT_W'(1)) == count_q) begin
          state_d = tfam_pkg::ST_DRAIN;
        end
      end
      tfam_pkg::ST_DRAIN: begin
        // wait for the read and multiply stages to empty
        if (!rd_vld_q && !mul_vld_q) begin
          state_d = tfam_pkg::ST_EMIT;
          k_d     = '0;
        end
      end
      tfam_pkg::ST_EMIT: begin
        if (out_accept) begin
          if (last) begin
            state_d = tfam_pkg::ST_LOAD;
            count_d = '0;
            sum_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            k_d = k_q + tfam_pkg::KIDX_W'(1);
          end
        end
      end
      default: state_d = tfam_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tfam_pkg::ST_LOAD;
      count_q   <= '0;
      sum_q     <= '0;
      ovf_q     <= 1'b0;
      scan_q    <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      ovf_q     <= ovf_d;
      scan_q    <= scan_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_en;
      mul_vld_q <= rd_vld_q;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while results pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tfam_pkg::CNT_W'(tfam_pkg::MAX_ITEMS))
    else $error("sample count beyond store depth");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || mul_vld_q) |-> (state_q == tfam_pkg::ST_DRAIN || state_q == tfam_pkg::ST_SCAN))
    else $error("scan pipeline busy outside scan");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && out_o.last_result) |=> (count_q == '0 && filled == '0 && !ovf_q))
    else $error("set state not cleared after last result");

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled <= tfam_pkg::FILL_W'(tfam_pkg::TOP_K))
    else $error("selection over-filled");

endmodule

/* design/tfam_store.sv */
// ----------------------------------------------------------------------------
// tfam_store: sample memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tfam_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [tfam_pkg::ADDR_W-1:0]   waddr_i,
  input  tfam_pkg::value_t              wdata_i,
  input  logic                          re_i,
  input  logic [tfam_pkg::ADDR_W-1:0]   raddr_i,
  output tfam_pkg::value_t              rdata_o
);

  tfam_pkg::value_t mem [tfam_pkg::MAX_ITEMS];
  tfam_pkg::value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tfam_topk.sv */
// ----------------------------------------------------------------------------
// tfam_topk: descending top-k list with registered insertion
// Entries at or above the new value stay; the rest shift down by one.
// ----------------------------------------------------------------------------
module tfam_topk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tfam_pkg::topk_ctrl_t          ctrl_i,
  input  tfam_pkg::value_t              value_i,
  output tfam_pkg::best_arr_t           best_o,
  output logic [tfam_pkg::FILL_W-1:0]   filled_o
);

  tfam_pkg::best_arr_t            best_q, best_d;
  logic [tfam_pkg::FILL_W-1:0]    filled_q, filled_d;
  logic [tfam_pkg::TOP_K-1:0]     keep;

  always_comb begin
    // list is sorted, so keep[] is a prefix: equal values stay ahead
    for (int i = 0; i < tfam_pkg::TOP_K; i++) begin
      keep[i] = (tfam_pkg::FILL_W'(i) < filled_q) && (best_q[i] >= value_i);
    end

    best_d   = best_q;
    filled_d = filled_q;
    if (ctrl_i.clear) begin
      filled_d = '0;
    end else if (ctrl_i.insert && !keep[tfam_pkg::TOP_K-1]) begin
      if (!keep[0]) begin
        best_d[0] = value_i;
      end
      for (int i = 1; i < tfam_pkg::TOP_K; i++) begin
        if (!keep[i]) begin
          best_d[i] = keep[i-1] ? value_i : best_q[i-1];
        end
      end
      if (filled_q != tfam_pkg::FILL_W'(tfam_pkg::TOP_K)) begin
        filled_d = filled_q + tfam_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign best_o   = best_q;
  assign filled_o = filled_q;

endmodule

/* verif/tfam_select_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfam_select_checker: scoreboard for the top-five-above-mean selector
// Watches both channels and keeps its own copy of the set being loaded. On the
// final input beat it works out the picks above the mean and queues them. Each
// output beat is compared field by field with the oldest queued pick.
// ----------------------------------------------------------------------------
module tfam_select_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfam_in_if         in_mon,
  tfam_out_if        out_mon,
  output int         fail_count_o,
  output int         picks_pending_o
);

  typedef struct {
    tfam_pkg::value_t chosen;
    logic             none;
    logic             last;
    logic             trunc;
  } pick_beat_t;

  tfam_pkg::value_t set_values [tfam_pkg::MAX_ITEMS];
  longint           set_sum;
  int               set_count;
  logic             set_dropped;
  pick_beat_t       pending_picks [$];

  // Top-k insertion over the stored set; v above the mean iff v*count > sum.
  task automatic predict_picks();
    tfam_pkg::value_t best [tfam_pkg::TOP_K];
    int               n_best;
    int               pos;
    pick_beat_t       pb;
    n_best = 0;
    for (int i = 0; i < set_count; i++) begin
      if (longint'(set_values[i]) * longint'(set_count) > set_sum) begin
        if (n_best < tfam_pkg::TOP_K) begin
          pos = n_best;
          n_best++;
        end else if (set_values[i] <= best[tfam_pkg::TOP_K-1]) begin
          continue;
        end else begin
          pos = tfam_pkg::TOP_K - 1;
        end
        while (pos > 0 && best[pos-1] < set_values[i]) begin
          best[pos] = best[pos-1];
          pos--;
        end
        best[pos] = set_values[i];
      end
    end
    if (n_best == 0) begin
      pb.chosen = '0;
      pb.none   = 1'b1;
      pb.last   = 1'b1;
      pb.trunc  = set_dropped;
      pending_picks = {pending_picks, pb};
    end else begin
      for (int k = 0; k < n_best; k++) begin
        pb.chosen = best[k];
        pb.none   = 1'b0;
        pb.last   = (k == n_best - 1);
        pb.trunc  = set_dropped;
        pending_picks = {pending_picks, pb};
      end
    end
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    pick_beat_t want;
    if (!rst_ni) begin
      set_sum     = 0;
      set_count   = 0;
      set_dropped = 1'b0;
      pending_picks.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_picks.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %0d", $time,
                   out_mon.chosen_value);
          fail_count_o++;
        end else begin
          want = pending_picks.pop_front();
          check_field("chosen_value", want.chosen, out_mon.chosen_value);
          check_field("none_above", want.none, out_mon.none_above);
          check_field("last_result", want.last, out_mon.last_result);
          check_field("truncated", want.trunc, out_mon.truncated);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (set_count < tfam_pkg::MAX_ITEMS) begin
          set_values[set_count] = in_mon.sample_value;
          set_sum += longint'(in_mon.sample_value);
          set_count++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_mon.final_item) begin
          predict_picks();
          set_sum     = 0;
          set_count   = 0;
          set_dropped = 1'b0;
        end
      end
    end
    picks_pending_o = pending_picks.size();
  end

endmodule

/* verif/tb_top_five_above_mean_select_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_five_above_mean_select_core: stimulus and verdict for the selector
// Sends directed sets (extremes, ties, nothing above the mean), then random
// sets of mixed size and a final stretch with no idling. Random gaps on the
// input and stalls on the output elsewhere.
// ----------------------------------------------------------------------------
module tb_top_five_above_mean_select_core;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BEATS = 400;
  localparam int QUIET_BEATS  = 80;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             idle_en = 1'b1;
  int               cycle_cnt = 0;
  int               stall_left = 0;
  int               beats_sent;
  int               fail_count;
  int               picks_pending;
  tfam_pkg::value_t last_value = '0;

  tfam_in_if  in_ch ();
  tfam_out_if out_ch ();

  top_five_above_mean_select_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tfam_select_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count_o    (fail_count),
    .picks_pending_o (picks_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output stalls in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_beat(input tfam_pkg::value_t v, input logic fin);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= v;
    in_ch.final_item   <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  function automatic tfam_pkg::value_t pick_value();
    tfam_pkg::value_t v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 200) - 100;
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: v = last_value;   // duplicates
    endcase
    last_value = v;
    return v;
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_beat(pick_value(), i == n - 1);
  endtask

  task automatic send_random_sets(input int beats);
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      if ($urandom_range(0, 7) == 0) send_random_set($urandom_range(13, 60));
      else send_random_set($urandom_range(1, 12));
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.sample_value <= '0;
    in_ch.final_item   <= 1'b0;
    beats_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single value: never above its own mean
    send_beat(42, 1'b1);
    // range extremes together
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh7fffffff, 1'b1);
    send_beat(-1, 1'b0);
    send_beat(0, 1'b0);
    send_beat(1, 1'b0);
    send_beat(32'sh7fffffff, 1'b0);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh55555555, 1'b0);
    send_beat(32'shaaaaaaaa, 1'b1);
    // all equal: nothing above
    repeat (3) send_beat(7, 1'b0);
    send_beat(7, 1'b1);
    // six tied values above the mean, only five kept
    repeat (6) send_beat(10, 1'b0);
    send_beat(-100, 1'b1);
    // most negative repeated
    repeat (2) send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh80000000, 1'b1);

    send_random_sets(RANDOM_BEATS);

    idle_en <= 1'b0;
    send_random_sets(QUIET_BEATS);
    in_ch.valid <= 1'b0;

    // let the checker register the final beat before polling
    @(posedge clk_i);
    while (picks_pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && picks_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
